/* hw/rtl/lcrm_pkg.sv */
// shared types, constants and result codes of the latin / cjk run marker
package lcrm_pkg;

    // run limit per kind and derived counter width
    localparam int MAX_RUNS  = 128;
    localparam int CNT_W     = $clog2(MAX_RUNS + 1);

    // field widths
    localparam int CP_W      = 21;
    localparam int KIND_W    = 4;
    localparam int IDX_W     = 7;
    localparam int MODE_W    = 2;

    // most results one request can cause
    localparam int MAX_RES   = 5;
    localparam int RES_CNT_W = $clog2(MAX_RES + 1);
    localparam int RES_PTR_W = $clog2(MAX_RES);

    // depth of the queue between front and back (at least two)
    localparam int QUEUE_DEPTH = 2;

    // result kinds
    localparam logic [KIND_W-1:0] K_PASS      = 4'd0;
    localparam logic [KIND_W-1:0] K_LAT_MARK  = 4'd1;
    localparam logic [KIND_W-1:0] K_CJK_MARK  = 4'd2;
    localparam logic [KIND_W-1:0] K_LAT_CAP   = 4'd3;
    localparam logic [KIND_W-1:0] K_CJK_CAP   = 4'd4;
    localparam logic [KIND_W-1:0] K_LAT_CLOSE = 4'd5;
    localparam logic [KIND_W-1:0] K_CJK_CLOSE = 4'd6;
    localparam logic [KIND_W-1:0] K_DISCARD   = 4'd7;
    localparam logic [KIND_W-1:0] K_ABORT     = 4'd8;
    localparam logic [KIND_W-1:0] K_END       = 4'd9;

    // open run modes
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LAT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_CJK  = 2'd2;

    // ideograph ranges, upper bound of the third one is exclusive
    localparam logic [CP_W-1:0] CJK_A_LO = 21'h02E80;
    localparam logic [CP_W-1:0] CJK_A_HI = 21'h02EFF;
    localparam logic [CP_W-1:0] CJK_B_LO = 21'h03400;
    localparam logic [CP_W-1:0] CJK_B_HI = 21'h04DBF;
    localparam logic [CP_W-1:0] CJK_C_LO = 21'h04E00;
    localparam logic [CP_W-1:0] CJK_C_EX = 21'h09FBF;
    localparam logic [CP_W-1:0] CJK_D_LO = 21'h0F900;
    localparam logic [CP_W-1:0] CJK_D_HI = 21'h0FAFF;

    // one result without its codepoint
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  idx;
    } res_t;

    // all results of one request
    typedef struct packed {
        logic [CP_W-1:0]       cp;
        logic [RES_CNT_W-1:0]  count;
        res_t [MAX_RES-1:0]    res;
    } job_t;

endpackage

/* hw/rtl/lcrm_front.sv */
// front end: classifies each codepoint, tracks the open run and builds its result list
module lcrm_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    output logic               item_stall,
    input  logic [20:0]        codepoint,
    input  logic               decode_error,
    input  logic               last,
    input  logic               q_full,
    output logic               q_push,
    output lcrm_pkg::job_t     q_job
);
    import lcrm_pkg::*;

    typedef struct packed {
        logic             hit;
        res_t             res;
        logic [CNT_W-1:0] lc;
        logic [CNT_W-1:0] cc;
    } close_t;

    logic [MODE_W-1:0] mode_reg, mode_next;
    logic [CNT_W-1:0]  lat_cnt_reg, lat_cnt_next;
    logic [CNT_W-1:0]  cjk_cnt_reg, cjk_cnt_next;

    logic                 is_lat, is_cjk;
    logic [MODE_W-1:0]    want;
    logic [RES_CNT_W-1:0] n;
    close_t               cr;
    job_t                 job;

    // close of the open run, with counter update
    function automatic close_t close_run(input logic [MODE_W-1:0] mode,
                                         input logic [CNT_W-1:0] lc,
                                         input logic [CNT_W-1:0] cc);
        close_t r;
        r = '0;
        r.lc = lc;
        r.cc = cc;
        if (mode == MODE_LAT) begin
            r.hit = 1'b1;
            if (lc < CNT_W'(MAX_RUNS)) begin
                r.res = '{kind: K_LAT_CLOSE, idx: IDX_W'(lc)};
                r.lc  = lc + 1'b1;
            end
            else begin
                r.res = '{kind: K_DISCARD, idx: '0};
            end
        end
        else if (mode == MODE_CJK) begin
            r.hit = 1'b1;
            if (cc < CNT_W'(MAX_RUNS)) begin
                r.res = '{kind: K_CJK_CLOSE, idx: IDX_W'(cc)};
                r.cc  = cc + 1'b1;
            end
            else begin
                r.res = '{kind: K_DISCARD, idx: '0};
            end
        end
        return r;
    endfunction

    // character class
    assign is_lat = (codepoint >= 21'h41 && codepoint <= 21'h5A) ||
                    (codepoint >= 21'h61 && codepoint <= 21'h7A);
    assign is_cjk = (codepoint >= CJK_A_LO && codepoint <= CJK_A_HI) ||
                    (codepoint >= CJK_B_LO && codepoint <= CJK_B_HI) ||
                    (codepoint >= CJK_C_LO && codepoint <  CJK_C_EX) ||
                    (codepoint >= CJK_D_LO && codepoint <= CJK_D_HI);

    // result list and next run state
    always_comb
    begin
        job          = '0;
        job.cp       = codepoint;
        n            = '0;
        cr           = '0;
        want         = is_lat ? MODE_LAT : MODE_CJK;
        mode_next    = mode_reg;
        lat_cnt_next = lat_cnt_reg;
        cjk_cnt_next = cjk_cnt_reg;
        if (decode_error) begin
            job.res[0]   = '{kind: K_ABORT, idx: '0};
            n            = RES_CNT_W'(1);
            mode_next    = MODE_NONE;
            lat_cnt_next = '0;
            cjk_cnt_next = '0;
        end
        else begin
            if (is_lat || is_cjk) begin
                if (mode_next != want) begin
                    cr = close_run(mode_next, lat_cnt_next, cjk_cnt_next);
                    if (cr.hit) begin
                        job.res[n] = cr.res;
                        n = n + 1'b1;
                    end
                    lat_cnt_next = cr.lc;
                    cjk_cnt_next = cr.cc;
                    job.res[n] = '{kind: (is_lat ? K_LAT_MARK : K_CJK_MARK), idx: '0};
                    n = n + 1'b1;
                    mode_next = want;
                end
                job.res[n] = '{kind: (is_lat ? K_LAT_CAP : K_CJK_CAP), idx: '0};
                n = n + 1'b1;
            end
            else begin
                job.res[n] = '{kind: K_PASS, idx: '0};
                n = n + 1'b1;
                cr = close_run(mode_next, lat_cnt_next, cjk_cnt_next);
                if (cr.hit) begin
                    job.res[n] = cr.res;
                    n = n + 1'b1;
                end
                lat_cnt_next = cr.lc;
                cjk_cnt_next = cr.cc;
                mode_next    = MODE_NONE;
            end
            if (last) begin
                cr = close_run(mode_next, lat_cnt_next, cjk_cnt_next);
                if (cr.hit) begin
                    job.res[n] = cr.res;
                    n = n + 1'b1;
                end
                job.res[n] = '{kind: K_END, idx: '0};
                n = n + 1'b1;
                mode_next    = MODE_NONE;
                lat_cnt_next = '0;
                cjk_cnt_next = '0;
            end
        end
        job.count = n;
    end

    assign item_stall = q_full;
    assign q_push     = item_valid && !q_full;
    assign q_job      = job;

    // run state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg    <= MODE_NONE;
            lat_cnt_reg <= '0;
            cjk_cnt_reg <= '0;
        end
        else if (q_push) begin
            mode_reg    <= mode_next;
            lat_cnt_reg <= lat_cnt_next;
            cjk_cnt_reg <= cjk_cnt_next;
        end
    end

endmodule

/* hw/rtl/lcrm_queue.sv */
// short job queue between front and back end
module lcrm_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  lcrm_pkg::job_t push_job,
    output logic           full,
    input  logic           pop,
    output lcrm_pkg::job_t pop_job,
    output logic           not_empty
);
    import lcrm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t              mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic              do_push, do_pop;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                     : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* hw/rtl/lcrm_back.sv */
// back end: holds one job and hands out its results one per cycle while result_stall is low
module lcrm_back (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           q_not_empty,
    input  lcrm_pkg::job_t q_job,
    output logic           q_pop,
    output logic           result_valid,
    input  logic           result_stall,
    output logic [3:0]     kind,
    output logic [20:0]    char_out,
    output logic [6:0]     run_index,
    output logic           last_result
);
    import lcrm_pkg::*;

    job_t                 job_reg;
    logic [RES_PTR_W-1:0] ptr_reg, ptr_next;
    logic                 busy_reg, busy_next;
    logic                 done, at_end, load;
    res_t                 cur;

    assign cur          = job_reg.res[ptr_reg];
    assign result_valid = busy_reg;
    assign kind         = cur.kind;
    assign run_index    = cur.idx;
    assign at_end       = (ptr_reg == RES_PTR_W'(job_reg.count - 1'b1));
    assign last_result  = at_end;

    // codepoint only on pass and capture results
    always_comb
    begin
        case (cur.kind) inside
            K_PASS, K_LAT_CAP, K_CJK_CAP: char_out = job_reg.cp;
            default:                      char_out = '0;
        endcase
    end

    // sequencing
    assign done  = busy_reg && !result_stall;
    assign load  = !busy_reg || (done && at_end);
    assign q_pop = load && q_not_empty;

    always_comb
    begin
        busy_next = busy_reg;
        ptr_next  = ptr_reg;
        if (load) begin
            busy_next = q_not_empty;
            ptr_next  = '0;
        end
        else if (done) begin
            ptr_next = ptr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop) begin
            job_reg <= q_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            ptr_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            ptr_reg  <= ptr_next;
        end
    end

endmodule

/* hw/rtl/latin_cjk_run_marker_unit.sv */
// Latin / CJK run marker: classifies codepoints and marks runs of letters or ideographs.
//
// Input channel (item_valid / item_stall): one decoded codepoint per request with
// decode_error and last flags. A request is taken when item_valid is high and
// item_stall is low; item_stall rises only while the job queue is full.
// Output channel (result_valid / result_stall): kind, char_out, run_index and
// last_result; last_result marks the final result of one input request.
// Each input causes one to five results. The front end classifies a request in
// the cycle it is taken and queues its whole result list; the back end hands out
// one result per cycle while result_stall is low, and plain text flows at one
// codepoint per cycle when the output does not stall.
// The first result of a request is valid once the request has passed through the
// queue and been loaded into the back end's job register.
// Reset clears the run mode, both run counters, the queue and the back end; no
// result is pending afterwards. While result_stall is high the current result
// holds; the queue fills behind it and then item_stall is raised.
module latin_cjk_run_marker_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [20:0] codepoint,
    input  logic        decode_error,
    input  logic        last,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [3:0]  kind,
    output logic [20:0] char_out,
    output logic [6:0]  run_index,
    output logic        last_result
);
    import lcrm_pkg::*;

    logic q_full, q_push, q_pop, q_not_empty;
    job_t push_job, pop_job;

    // classify and build result lists
    lcrm_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .codepoint    (codepoint),
        .decode_error (decode_error),
        .last         (last),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_job        (push_job)
    );

    // decoupling queue
    lcrm_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .pop_job   (pop_job),
        .not_empty (q_not_empty)
    );

    // result sequencing
    lcrm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_not_empty  (q_not_empty),
        .q_job        (pop_job),
        .q_pop        (q_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .kind         (kind),
        .char_out     (char_out),
        .run_index    (run_index),
        .last_result  (last_result)
    );

    // abort and end always close out the request
    a_term_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == K_ABORT || kind == K_END) |-> last_result)
        else $error("abort or end result not marked last");

    // a marker is always followed by its capture
    a_mark_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (kind == K_LAT_MARK || kind == K_CJK_MARK) |-> !last_result)
        else $error("marker result marked last");

    // codepoint only travels with pass and capture results
    a_char_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && kind != K_PASS && kind != K_LAT_CAP && kind != K_CJK_CAP
        |-> char_out == '0)
        else $error("char_out set on a result without a codepoint");

endmodule

/* test/testbench.sv */
// self-checking testbench of the latin / cjk run marker unit
module testbench;
    import lcrm_pkg::*;

    // one text request: codepoint with its flags
    typedef struct {
        logic [CP_W-1:0] cp;
        logic            err;
        logic            eos;
    } text_req_t;

    // one expected result of the run marker
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [CP_W-1:0]   ch;
        logic [IDX_W-1:0]  idx;
        logic              fin;
    } mark_res_t;

    // character classes used to shape the stimulus
    typedef enum int {CLS_LATIN, CLS_CJK, CLS_OTHER} char_class_e;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              item_valid = 1'b0;
    logic              item_stall;
    logic [CP_W-1:0]   codepoint = '0;
    logic              decode_error = 1'b0;
    logic              last = 1'b0;
    logic              result_valid;
    logic              result_stall = 1'b0;
    logic [KIND_W-1:0] kind;
    logic [CP_W-1:0]   char_out;
    logic [IDX_W-1:0]  run_index;
    logic              last_result;

    text_req_t   text_reqs[$];
    mark_res_t   marked_results[$];
    logic [1:0]  open_mode = MODE_NONE;
    int unsigned latin_stored = 0;
    int unsigned cjk_stored = 0;
    int          items_taken = 0;
    int          mismatches = 0;
    logic        req_taken = 1'b0;
    logic        res_taken = 1'b0;
    logic        hold_off = 1'b0;
    int          send_wait = 0;
    int          recv_wait = 0;
    bit          send_calm = 1'b0;
    bit          recv_calm = 1'b0;

    latin_cjk_run_marker_unit dut (
        .clk, .rst_n, .item_valid, .item_stall, .codepoint, .decode_error, .last,
        .result_valid, .result_stall, .kind, .char_out, .run_index, .last_result
    );

    // clock
    initial begin
        forever #5 clk = ~clk;
    end

    // letter and ideograph classification
    function automatic bit is_latin_cp(input logic [CP_W-1:0] c);
        return (c >= 'h41 && c <= 'h5A) || (c >= 'h61 && c <= 'h7A);
    endfunction

    function automatic bit is_cjk_cp(input logic [CP_W-1:0] c);
        return (c >= CJK_A_LO && c <= CJK_A_HI) || (c >= CJK_B_LO && c <= CJK_B_HI) ||
               (c >= CJK_C_LO && c < CJK_C_EX) || (c >= CJK_D_LO && c <= CJK_D_HI);
    endfunction

    task automatic push_mark(input logic [KIND_W-1:0] k, input logic [CP_W-1:0] ch,
                             input logic [IDX_W-1:0] idx);
        marked_results.push_back('{k, ch, idx, 1'b0});
    endtask

    // close the open run, or discard it once its kind is full
    task automatic close_open_run();
        if (open_mode == MODE_LAT) begin
            if (latin_stored < MAX_RUNS) begin
                push_mark(K_LAT_CLOSE, '0, latin_stored[IDX_W-1:0]);
                latin_stored++;
            end else begin
                push_mark(K_DISCARD, '0, '0);
            end
        end else if (open_mode == MODE_CJK) begin
            if (cjk_stored < MAX_RUNS) begin
                push_mark(K_CJK_CLOSE, '0, cjk_stored[IDX_W-1:0]);
                cjk_stored++;
            end else begin
                push_mark(K_DISCARD, '0, '0);
            end
        end
        open_mode = MODE_NONE;
    endtask

    task automatic clear_string();
        open_mode = MODE_NONE;
        latin_stored = 0;
        cjk_stored = 0;
    endtask

    // expected results of one accepted request
    task automatic mark_codepoint(input logic [CP_W-1:0] c, input logic err, input logic eos);
        logic [1:0] want;
        if (err) begin
            push_mark(K_ABORT, '0, '0);
            clear_string();
        end else begin
            if (is_latin_cp(c) || is_cjk_cp(c)) begin
                want = is_latin_cp(c) ? MODE_LAT : MODE_CJK;
                if (open_mode != want) begin
                    close_open_run();
                    push_mark(want == MODE_LAT ? K_LAT_MARK : K_CJK_MARK, '0, '0);
                    open_mode = want;
                end
                push_mark(want == MODE_LAT ? K_LAT_CAP : K_CJK_CAP, c, '0);
            end else begin
                push_mark(K_PASS, c, '0);
                close_open_run();
            end
            if (eos) begin
                close_open_run();
                push_mark(K_END, '0, '0);
                clear_string();
            end
        end
        marked_results[marked_results.size() - 1].fin = 1'b1;
    endtask

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endtask

    // wait cycles drawn per item, with calm stretches of no idling
    function automatic int draw_wait(input bit calm);
        if (calm || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 15);
    endfunction

    // codepoint of a given class, drawn at random from that class's ranges
    function automatic logic [CP_W-1:0] pick_char(input char_class_e cls);
        logic [CP_W-1:0] c;
        case (cls)
            CLS_LATIN: c = CP_W'($urandom_range(0, 1) ? $urandom_range('h41, 'h5A)
                                                       : $urandom_range('h61, 'h7A));
            CLS_CJK: begin
                case ($urandom_range(0, 3))
                    0: c = CP_W'($urandom_range(CJK_A_LO, CJK_A_HI));
                    1: c = CP_W'($urandom_range(CJK_B_LO, CJK_B_HI));
                    2: c = CP_W'($urandom_range(CJK_C_LO, CJK_C_EX - 1));
                    default: c = CP_W'($urandom_range(CJK_D_LO, CJK_D_HI));
                endcase
            end
            default: begin
                case ($urandom_range(0, 7))
                    0: c = CP_W'($urandom_range(0, 'h40));
                    1: c = CP_W'($urandom_range('h5B, 'h60));
                    2: c = CP_W'($urandom_range('h7B, 'h2E7F));
                    3: c = CP_W'($urandom_range(CJK_C_EX, 'hF8FF));
                    4: c = CP_W'($urandom_range('hD800, 'hDFFF));
                    5: c = CP_W'($urandom_range('h110000, 'h1FFFFF));
                    6: c = CP_W'($urandom_range(0, 'h1FFFFF));
                    default: c = $urandom_range(0, 1) ? 21'h2F00 : 21'hFB00;
                endcase
            end
        endcase
        return c;
    endfunction

    task automatic add_req(input logic [CP_W-1:0] c, input logic err, input logic eos);
        text_reqs.push_back('{c, err, eos});
    endtask

    // one string with runs of random content and rare decode errors
    task automatic add_string(input int len);
        char_class_e cls;
        cls = char_class_e'($urandom_range(0, 2));
        for (int i = 0; i < len; i++) begin
            if ($urandom_range(0, 2) == 0)
                cls = char_class_e'($urandom_range(0, 2));
            if ($urandom_range(0, 39) == 0)
                add_req(CP_W'($urandom_range(0, 'h1FFFFF)), 1'b1, 1'($urandom_range(0, 1)));
            else
                add_req(pick_char(cls), 1'b0, i == len - 1);
        end
    endtask

    // sender: next request after its drawn gap, payload held while stalled
    always @(negedge clk) begin : send_side
        text_req_t nxt;
        if (rst_n && (!item_valid || req_taken)) begin
            if (send_wait > 0) begin
                send_wait <= send_wait - 1;
                item_valid <= 1'b0;
            end else if (text_reqs.size() != 0) begin
                nxt = text_reqs.pop_front();
                codepoint <= nxt.cp;
                decode_error <= nxt.err;
                last <= nxt.eos;
                item_valid <= 1'b1;
                if ($urandom_range(0, 19) == 0)
                    send_calm = !send_calm;
                send_wait <= draw_wait(send_calm);
            end else begin
                item_valid <= 1'b0;
            end
        end
    end

    // receiver: drawn stall before each result, plus the long hold-off
    always @(negedge clk) begin : recv_side
        if (rst_n) begin
            if (res_taken) begin
                if ($urandom_range(0, 19) == 0)
                    recv_calm = !recv_calm;
                recv_wait = draw_wait(recv_calm);
            end
            if (hold_off) begin
                result_stall <= 1'b1;
            end else if (recv_wait > 0) begin
                recv_wait--;
                result_stall <= 1'b1;
            end else begin
                result_stall <= 1'b0;
            end
        end
    end

    // long receiver hold-off so the unit backs up and stalls its input
    initial begin : hold_process
        while (items_taken < 40)
            @(posedge clk);
        hold_off <= 1'b1;
        repeat (400) @(posedge clk);
        hold_off <= 1'b0;
    end

    // predict on accepted requests, compare accepted results
    always @(posedge clk) begin : watch
        mark_res_t want;
        req_taken <= rst_n && item_valid && !item_stall;
        res_taken <= rst_n && result_valid && !result_stall;
        if (rst_n && item_valid && !item_stall) begin
            mark_codepoint(codepoint, decode_error, last);
            items_taken++;
        end
        if (rst_n && result_valid && !result_stall) begin
            if (marked_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected kind %0d char %h idx %0d last %0b",
                                        kind, char_out, run_index, last_result));
            end else begin
                want = marked_results.pop_front();
                if (kind !== want.kind || char_out !== want.ch ||
                    run_index !== want.idx || last_result !== want.fin)
                    flag_mismatch($sformatf(
                        "expected kind %0d char %h idx %0d last %0b, got %0d %h %0d %0b",
                        want.kind, want.ch, want.idx, want.fin,
                        kind, char_out, run_index, last_result));
            end
        end
    end

    // stimulus, reset and end of run
    initial begin : stimulus
        int total;
        // directed: range edges, every result kind but discard, abort and longest result list
        add_req(21'h000000, 1'b0, 1'b0);
        add_req(21'h000041, 1'b0, 1'b0);
        add_req(21'h00005A, 1'b0, 1'b0);
        add_req(21'h000040, 1'b0, 1'b0);
        add_req(21'h000061, 1'b0, 1'b0);
        add_req(21'h00007A, 1'b0, 1'b0);
        add_req(21'h002E80, 1'b0, 1'b0);
        add_req(21'h002EFF, 1'b0, 1'b0);
        add_req(21'h009FBE, 1'b0, 1'b0);
        add_req(21'h009FBF, 1'b0, 1'b0);
        add_req(21'h003400, 1'b0, 1'b0);
        add_req(21'h004DBF, 1'b0, 1'b0);
        add_req(21'h00005B, 1'b0, 1'b0);
        add_req(21'h004E00, 1'b0, 1'b0);
        add_req(21'h00F900, 1'b0, 1'b0);
        add_req(21'h00FAFF, 1'b0, 1'b1);
        add_req(21'h000060, 1'b0, 1'b1);
        add_req(21'h000062, 1'b0, 1'b0);
        add_req(21'h004E01, 1'b0, 1'b1);
        add_req(21'h00D800, 1'b0, 1'b0);
        add_req(21'h10FFFF, 1'b0, 1'b0);
        add_req(21'h1FFFFF, 1'b0, 1'b0);
        add_req(21'h002E7F, 1'b0, 1'b0);
        add_req(21'h000051, 1'b0, 1'b0);
        add_req(21'h1FFFFF, 1'b1, 1'b1);

        // random strings, with one long string that runs into the run limit of both kinds
        for (int s = 0; s < 10; s++) begin
            add_string($urandom_range(1, 6));
            if (s == 4) begin
                for (int i = 0; i < 260; i++) begin
                    if ($urandom_range(0, 19) == 0)
                        add_req(pick_char(CLS_OTHER), 1'b0, 1'b0);
                    add_req(pick_char(i % 2 ? CLS_CJK : CLS_LATIN), 1'b0, i == 259);
                end
            end
        end
        total = text_reqs.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (items_taken < total)
            @(posedge clk);
        while (marked_results.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        if (mismatches == 0)
            $display("latin_cjk_run_marker_unit test passed");
        else
            $display("latin_cjk_run_marker_unit test failed");
        $finish;
    end

    // run limit
    initial begin : watchdog
        #3000000;
        $display("latin_cjk_run_marker_unit test failed");
        $finish;
    end

endmodule

/* filelist.f */
hw/rtl/lcrm_pkg.sv
hw/rtl/lcrm_front.sv
hw/rtl/lcrm_queue.sv
hw/rtl/lcrm_back.sv
hw/rtl/latin_cjk_run_marker_unit.sv
test/testbench.sv
